/* hw/rtl/sbi_pkg.sv */
// Shared types, widths and a helper function for the segment and box intersection pipeline.
package sbi_pkg;

    // Coordinate width and the widths derived from it.
    localparam int CoordW = 32;
    localparam int EdgeW  = CoordW + 1;
    localparam int DifW   = CoordW + 1;
    localparam int NumW   = CoordW + 2;
    localparam int ProdW  = NumW + DifW;
    localparam int QuoW   = CoordW + 3;
    localparam int RemW   = CoordW + 1;
    localparam int TW     = CoordW + 4;
    localparam int DivLat = QuoW + 2;
    localparam int Lanes  = 4;

    typedef enum logic [1:0] {
        EDGE_BOTTOM = 2'd0,
        EDGE_LEFT   = 2'd1,
        EDGE_RIGHT  = 2'd2,
        EDGE_TOP    = 2'd3
    } edge_t;

    typedef struct packed {
        logic signed [CoordW-1:0] start_x;
        logic signed [CoordW-1:0] start_y;
        logic signed [CoordW-1:0] end_x;
        logic signed [CoordW-1:0] end_y;
        logic signed [CoordW-1:0] box_center_x;
        logic signed [CoordW-1:0] box_center_y;
        logic [CoordW-2:0]        box_width;
        logic [CoordW-2:0]        box_height;
    } query_t;

    typedef struct packed {
        logic                     hit;
        edge_t                    hit_edge;
        logic signed [CoordW-1:0] hit_x;
        logic signed [CoordW-1:0] hit_y;
    } result_t;

    // Values that ride alongside the dividers until the final selection.
    typedef struct packed {
        logic                     reject;
        logic signed [EdgeW-1:0]  left;
        logic signed [EdgeW-1:0]  right;
        logic signed [EdgeW-1:0]  top;
        logic signed [EdgeW-1:0]  bottom;
        logic signed [CoordW-1:0] sx;
        logic signed [CoordW-1:0] sy;
    } side_t;

    // One divider lane computes trunc(num * mul / div).
    typedef struct packed {
        logic signed [NumW-1:0] num;
        logic signed [DifW-1:0] mul;
        logic signed [DifW-1:0] div;
    } lane_in_t;

    typedef struct packed {
        logic                 skip;
        logic                 big;
        logic signed [TW-1:0] quo;
    } lane_out_t;

    // Saturate a wide signed value to the coordinate range.
    function automatic logic [CoordW-1:0] clamp_coord(input logic signed [TW-1:0] v);
        logic signed [TW-1:0] hi_lim;
        logic signed [TW-1:0] lo_lim;
        hi_lim = {{(TW-CoordW+1){1'b0}}, {(CoordW-1){1'b1}}};
        lo_lim = ~hi_lim;
        if (v > hi_lim)
        begin
            return hi_lim[CoordW-1:0];
        end
        else if (v < lo_lim)
        begin
            return lo_lim[CoordW-1:0];
        end
        return v[CoordW-1:0];
    endfunction

endpackage

/* hw/rtl/segment_box_intersection.sv */
// Top level of the segment against axis-aligned box intersection pipeline.
// The block takes one query in every clock cycle and never raises busy. Each
// query gives exactly one result, shown with done for a single cycle; the
// receiver cannot hold results off. Each query passes through the four divider
// lanes, which resolve one quotient bit per stage after a registered multiply,
// with one front stage before them and one selection stage after.
module segment_box_intersection (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  sbi_pkg::query_t  query,
    output logic             done,
    output sbi_pkg::result_t result
);
    import sbi_pkg::*;

    side_t                 front_side;
    lane_in_t  [Lanes-1:0] front_lane;
    lane_out_t [Lanes-1:0] div_out;
    logic                  front_vld_reg;
    logic                  vld_reg  [0:DivLat-1];
    side_t                 side_reg [0:DivLat-1];

    assign busy = 1'b0;

    sbi_front u_front (
        .clk   (clk),
        .query (query),
        .side  (front_side),
        .lane  (front_lane)
    );

    for (genvar i = 0; i < Lanes; i++)
    begin : g_lane
        sbi_divider u_div (
            .clk  (clk),
            .lin  (front_lane[i]),
            .lout (div_out[i])
        );
    end

    // Valid bits follow the items through the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_vld_reg <= 1'b0;
            for (int k = 0; k < DivLat; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            front_vld_reg <= start;
            vld_reg[0]    <= front_vld_reg;
            for (int k = 1; k < DivLat; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // Edges and start point travel alongside the dividers.
    always_ff @(posedge clk)
    begin
        side_reg[0] <= front_side;
        for (int k = 1; k < DivLat; k++)
        begin
            side_reg[k] <= side_reg[k-1];
        end
    end

    sbi_select u_select (
        .clk    (clk),
        .rst_n  (rst_n),
        .valid  (vld_reg[DivLat-1]),
        .side   (side_reg[DivLat-1]),
        .lane   (div_out),
        .done   (done),
        .result (result)
    );

`ifndef NO_ASSERTIONS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(DivLat + 2) done)
        else $error("query did not produce a result at the expected latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, DivLat + 2))
        else $error("result without a matching query");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.hit) |->
            (result.hit_x == '0 && result.hit_y == '0 && result.hit_edge == EDGE_BOTTOM))
        else $error("miss carries non-zero fields");
`endif

endmodule

/* hw/rtl/sbi_front.sv */
// Front stage: box edges, segment deltas, trivial rejection and the divider operands.
module sbi_front (
    input  logic                                  clk,
    input  sbi_pkg::query_t                       query,
    output sbi_pkg::side_t                        side,
    output sbi_pkg::lane_in_t [sbi_pkg::Lanes-1:0] lane
);
    import sbi_pkg::*;

    logic signed [EdgeW-1:0] sx_e, sy_e, ex_e, ey_e, cx_e, cy_e, hw_e, hh_e;
    logic signed [EdgeW-1:0] left, right, top, bottom;
    logic signed [DifW-1:0]  dx, dy;
    logic                    reject;
    side_t                   side_next, side_reg;
    lane_in_t [Lanes-1:0]    lane_next, lane_reg;

    // Sign-extend the coordinates and halve the sizes.
    always_comb
    begin
        sx_e   = {query.start_x[CoordW-1], query.start_x};
        sy_e   = {query.start_y[CoordW-1], query.start_y};
        ex_e   = {query.end_x[CoordW-1], query.end_x};
        ey_e   = {query.end_y[CoordW-1], query.end_y};
        cx_e   = {query.box_center_x[CoordW-1], query.box_center_x};
        cy_e   = {query.box_center_y[CoordW-1], query.box_center_y};
        hw_e   = {3'b000, query.box_width[CoordW-2:1]};
        hh_e   = {3'b000, query.box_height[CoordW-2:1]};
        left   = cx_e - hw_e;
        right  = cx_e + hw_e;
        top    = cy_e + hh_e;
        bottom = cy_e - hh_e;
        dx     = ex_e - sx_e;
        dy     = ey_e - sy_e;
    end

    // Both ends beyond one edge means no crossing at all.
    always_comb
    begin
        reject = (sx_e <= left && ex_e <= left) || (sx_e >= right && ex_e >= right) ||
                 (sy_e >= top && ey_e >= top) || (sy_e <= bottom && ey_e <= bottom);
    end

    // Operands for one crossing on each edge, in bottom, left, right, top order.
    always_comb
    begin
        side_next.reject = reject;
        side_next.left   = left;
        side_next.right  = right;
        side_next.top    = top;
        side_next.bottom = bottom;
        side_next.sx     = query.start_x;
        side_next.sy     = query.start_y;
        lane_next[EDGE_BOTTOM].num = {bottom[EdgeW-1], bottom} - {sy_e[EdgeW-1], sy_e};
        lane_next[EDGE_BOTTOM].mul = dx;
        lane_next[EDGE_BOTTOM].div = dy;
        lane_next[EDGE_LEFT].num   = {left[EdgeW-1], left} - {sx_e[EdgeW-1], sx_e};
        lane_next[EDGE_LEFT].mul   = dy;
        lane_next[EDGE_LEFT].div   = dx;
        lane_next[EDGE_RIGHT].num  = {right[EdgeW-1], right} - {sx_e[EdgeW-1], sx_e};
        lane_next[EDGE_RIGHT].mul  = dy;
        lane_next[EDGE_RIGHT].div  = dx;
        lane_next[EDGE_TOP].num    = {top[EdgeW-1], top} - {sy_e[EdgeW-1], sy_e};
        lane_next[EDGE_TOP].mul    = dx;
        lane_next[EDGE_TOP].div    = dy;
    end

    always_ff @(posedge clk)
    begin
        side_reg <= side_next;
        lane_reg <= lane_next;
    end

    assign side = side_reg;
    assign lane = lane_reg;

endmodule

/* hw/rtl/sbi_divider.sv */
// One divider lane: a registered multiply followed by a restoring divide, one quotient bit a stage.
module sbi_divider (
    input  logic                clk,
    input  sbi_pkg::lane_in_t   lin,
    output sbi_pkg::lane_out_t  lout
);
    import sbi_pkg::*;

    logic [NumW-1:0]  amag;
    logic [DifW-1:0]  bmag, cmag;
    logic [ProdW-1:0] prod_reg;
    logic [RemW-1:0]  dm_reg;
    logic             neg_m_reg, skip_m_reg;
    logic [CoordW-1:0] hi_part;
    logic             big_next;

    logic [RemW-1:0]  rem_reg  [0:QuoW];
    logic [QuoW-1:0]  low_reg  [0:QuoW];
    logic [QuoW-1:0]  quo_reg  [0:QuoW];
    logic [RemW-1:0]  d_reg    [0:QuoW];
    logic             neg_reg  [0:QuoW];
    logic             skip_reg [0:QuoW];
    logic             big_reg  [0:QuoW];

    // Magnitudes of the operands.
    always_comb
    begin
        amag = lin.num[NumW-1] ? NumW'(-lin.num) : NumW'(lin.num);
        bmag = lin.mul[DifW-1] ? DifW'(-lin.mul) : DifW'(lin.mul);
        cmag = lin.div[DifW-1] ? DifW'(-lin.div) : DifW'(lin.div);
    end

    // Multiply stage.
    always_ff @(posedge clk)
    begin
        prod_reg   <= ProdW'(amag) * ProdW'(bmag);
        dm_reg     <= cmag;
        neg_m_reg  <= lin.num[NumW-1] ^ lin.mul[DifW-1] ^ lin.div[DifW-1];
        skip_m_reg <= (lin.div == '0);
    end

    // A quotient too large for the low bits can never land on an edge.
    always_comb
    begin
        hi_part  = prod_reg[ProdW-1:QuoW];
        big_next = ({1'b0, hi_part} >= dm_reg);
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= big_next ? '0 : RemW'(hi_part);
        low_reg[0]  <= prod_reg[QuoW-1:0];
        quo_reg[0]  <= '0;
        d_reg[0]    <= dm_reg;
        neg_reg[0]  <= neg_m_reg;
        skip_reg[0] <= skip_m_reg;
        big_reg[0]  <= big_next;
    end

    // Restoring division, one bit per stage.
    for (genvar j = 1; j <= QuoW; j++)
    begin : g_step
        logic [RemW:0] trial;
        logic          ge;
        always_comb
        begin
            trial = {rem_reg[j-1], low_reg[j-1][QuoW-1]};
            ge    = (trial >= {1'b0, d_reg[j-1]});
        end
        always_ff @(posedge clk)
        begin
            rem_reg[j]  <= ge ? RemW'(trial - {1'b0, d_reg[j-1]}) : trial[RemW-1:0];
            low_reg[j]  <= {low_reg[j-1][QuoW-2:0], 1'b0};
            quo_reg[j]  <= {quo_reg[j-1][QuoW-2:0], ge};
            d_reg[j]    <= d_reg[j-1];
            neg_reg[j]  <= neg_reg[j-1];
            skip_reg[j] <= skip_reg[j-1];
            big_reg[j]  <= big_reg[j-1];
        end
    end

    // Apply the sign; truncation toward zero follows from dividing magnitudes.
    always_comb
    begin
        lout.skip = skip_reg[QuoW];
        lout.big  = big_reg[QuoW];
        lout.quo  = neg_reg[QuoW] ? -$signed({1'b0, quo_reg[QuoW]})
                                  : $signed({1'b0, quo_reg[QuoW]});
    end

endmodule

/* hw/rtl/sbi_select.sv */
// Final stage: crossing points, edge tests in priority order and the output register.
module sbi_select (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   valid,
    input  sbi_pkg::side_t                         side,
    input  sbi_pkg::lane_out_t [sbi_pkg::Lanes-1:0] lane,
    output logic                                   done,
    output sbi_pkg::result_t                       result
);
    import sbi_pkg::*;

    logic signed [TW-1:0] sx_t, sy_t, left_t, right_t, top_t, bottom_t;
    logic signed [TW-1:0] t_b, t_l, t_r, t_t;
    logic                 ok_b, ok_l, ok_r, ok_t;
    result_t              res_next, res_reg;
    logic                 done_reg;

    // Crossing coordinates along each edge.
    always_comb
    begin
        sx_t     = TW'(side.sx);
        sy_t     = TW'(side.sy);
        left_t   = TW'(side.left);
        right_t  = TW'(side.right);
        top_t    = TW'(side.top);
        bottom_t = TW'(side.bottom);
        t_b = lane[EDGE_BOTTOM].quo + sx_t;
        t_l = lane[EDGE_LEFT].quo + sy_t;
        t_r = lane[EDGE_RIGHT].quo + sy_t;
        t_t = lane[EDGE_TOP].quo + sx_t;
        ok_b = !lane[EDGE_BOTTOM].skip && !lane[EDGE_BOTTOM].big &&
               t_b > left_t && t_b < right_t;
        ok_l = !lane[EDGE_LEFT].skip && !lane[EDGE_LEFT].big &&
               t_l < top_t && t_l > bottom_t;
        ok_r = !lane[EDGE_RIGHT].skip && !lane[EDGE_RIGHT].big &&
               t_r < top_t && t_r > bottom_t;
        ok_t = !lane[EDGE_TOP].skip && !lane[EDGE_TOP].big &&
               t_t > left_t && t_t < right_t;
    end

    // The first crossed edge in bottom, left, right, top order wins; a rejected segment reports nothing.
    always_comb
    begin
        res_next = '0;
        if (!side.reject)
        begin
            if (ok_b)
            begin
                res_next.hit      = 1'b1;
                res_next.hit_edge = EDGE_BOTTOM;
                res_next.hit_x    = clamp_coord(t_b);
                res_next.hit_y    = clamp_coord(bottom_t);
            end
            else if (ok_l)
            begin
                res_next.hit      = 1'b1;
                res_next.hit_edge = EDGE_LEFT;
                res_next.hit_x    = clamp_coord(left_t);
                res_next.hit_y    = clamp_coord(t_l);
            end
            else if (ok_r)
            begin
                res_next.hit      = 1'b1;
                res_next.hit_edge = EDGE_RIGHT;
                res_next.hit_x    = clamp_coord(right_t);
                res_next.hit_y    = clamp_coord(t_r);
            end
            else if (ok_t)
            begin
                res_next.hit      = 1'b1;
                res_next.hit_edge = EDGE_TOP;
                res_next.hit_x    = clamp_coord(t_t);
                res_next.hit_y    = clamp_coord(top_t);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

/* tb/sbi_checker.sv */
// Checker that predicts every intersection result from the accepted queries and compares it.
`timescale 1ns / 100ps

module sbi_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  sbi_pkg::query_t  query,
    input  logic             done,
    input  sbi_pkg::result_t result,
    output int               fail_count,
    output int               pending_count
);
    import sbi_pkg::*;

    localparam longint CoordMax = (longint'(1) <<< (CoordW - 1)) - 1;
    localparam longint CoordMin = -(longint'(1) <<< (CoordW - 1));

    result_t expected_results[$];

    // Truncated a * b / c with the quotient magnitude held at 2^62.
    function automatic longint scaled_quotient(input longint a, input longint b,
                                               input longint c);
        logic [127:0] ma;
        logic [127:0] mb;
        logic [127:0] md;
        logic [127:0] qt;
        logic         neg;
        neg = ((a < 0) != (b < 0)) != (c < 0);
        ma  = (a < 0) ? 128'(-a) : 128'(a);
        mb  = (b < 0) ? 128'(-b) : 128'(b);
        md  = (c < 0) ? 128'(-c) : 128'(c);
        qt  = (ma * mb) / md;
        if (qt >= (128'd1 << 62))
        begin
            qt = 128'd1 << 62;
        end
        return neg ? -longint'(qt[63:0]) : longint'(qt[63:0]);
    endfunction

    // Saturate a wide value to the coordinate range.
    function automatic logic signed [CoordW-1:0] sat_coord(input longint v);
        if (v > CoordMax)
        begin
            v = CoordMax;
        end
        if (v < CoordMin)
        begin
            v = CoordMin;
        end
        return v[CoordW-1:0];
    endfunction

    // Work out the crossing of the segment's line with the box edges.
    function automatic result_t predict_crossing(input query_t q);
        longint  sx;
        longint  sy;
        longint  ex;
        longint  ey;
        longint  lft;
        longint  rgt;
        longint  tp;
        longint  btm;
        longint  dx;
        longint  dy;
        longint  px;
        longint  py;
        longint  t;
        logic    found;
        result_t r;
        sx  = longint'(q.start_x);
        sy  = longint'(q.start_y);
        ex  = longint'(q.end_x);
        ey  = longint'(q.end_y);
        lft = longint'(q.box_center_x) - longint'(q.box_width >> 1);
        rgt = longint'(q.box_center_x) + longint'(q.box_width >> 1);
        tp  = longint'(q.box_center_y) + longint'(q.box_height >> 1);
        btm = longint'(q.box_center_y) - longint'(q.box_height >> 1);
        dx  = ex - sx;
        dy  = ey - sy;
        px  = 0;
        py  = 0;
        found = 1'b0;
        r = '0;
        r.hit_edge = EDGE_BOTTOM;
        // Both ends beyond one edge: no crossing at all.
        if ((sx <= lft && ex <= lft) || (sx >= rgt && ex >= rgt) ||
            (sy >= tp && ey >= tp) || (sy <= btm && ey <= btm))
        begin
            return r;
        end
        if (dy != 0)
        begin
            t = scaled_quotient(btm - sy, dx, dy) + sx;
            if (t > lft && t < rgt)
            begin
                found = 1'b1; r.hit_edge = EDGE_BOTTOM; px = t; py = btm;
            end
        end
        if (!found && dx != 0)
        begin
            t = scaled_quotient(lft - sx, dy, dx) + sy;
            if (t < tp && t > btm)
            begin
                found = 1'b1; r.hit_edge = EDGE_LEFT; px = lft; py = t;
            end
        end
        if (!found && dx != 0)
        begin
            t = scaled_quotient(rgt - sx, dy, dx) + sy;
            if (t < tp && t > btm)
            begin
                found = 1'b1; r.hit_edge = EDGE_RIGHT; px = rgt; py = t;
            end
        end
        if (!found && dy != 0)
        begin
            t = scaled_quotient(tp - sy, dx, dy) + sx;
            if (t > lft && t < rgt)
            begin
                found = 1'b1; r.hit_edge = EDGE_TOP; px = t; py = tp;
            end
        end
        if (found)
        begin
            r.hit   = 1'b1;
            r.hit_x = sat_coord(px);
            r.hit_y = sat_coord(py);
        end
        else
        begin
            r.hit_edge = EDGE_BOTTOM;
        end
        return r;
    endfunction

    // Record a mismatch, describing only the first ten of them.
    task automatic note_failure(input string what, input result_t exp_r,
                                input result_t got_r);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("t=%0t %s: expected hit=%0d edge=%0d x=%0d y=%0d, got hit=%0d edge=%0d x=%0d y=%0d",
                     $time, what, exp_r.hit, exp_r.hit_edge, exp_r.hit_x, exp_r.hit_y,
                     got_r.hit, got_r.hit_edge, got_r.hit_x, got_r.hit_y);
        end
    endtask

    // Predict on each accepted item and compare each result with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_r;
        if (!rst_n)
        begin
            expected_results.delete();
            fail_count    <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    note_failure("unexpected result", '0, result);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (exp_r.hit !== result.hit || exp_r.hit_edge !== result.hit_edge ||
                        exp_r.hit_x !== result.hit_x || exp_r.hit_y !== result.hit_y)
                    begin
                        note_failure("result mismatch", exp_r, result);
                    end
                end
            end
            if (start && !busy)
            begin
                expected_results.push_back(predict_crossing(query));
            end
            pending_count <= expected_results.size();
        end
    end

endmodule

/* tb/tb_segment_box_intersection.sv */
// Stimulus and verdict for the segment and box intersection block.
`timescale 1ns / 100ps

module tb_segment_box_intersection;
    import sbi_pkg::*;

    localparam int RandomItems = 1750;
    localparam int DrainCycles = 80;
    localparam int Q           = 1 << 16;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    query_t  query;
    logic    done;
    result_t result;
    int      fail_count;
    int      pending_count;

    segment_box_intersection u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .query  (query),
        .done   (done),
        .result (result)
    );

    sbi_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .query         (query),
        .done          (done),
        .result        (result),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Clock with a 2 ns period.
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Idle gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            return 0;
        end
        else if (roll < 92)
        begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(15, 60);
    endfunction

    // Present one item, wait until it is taken, then idle for the chosen gap.
    task automatic send_item(input query_t q, input int gap);
        start <= 1'b1;
        query <= q;
        @(negedge clk);
        while (busy)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Build an item from whole-unit coordinates around a box of full size w by h.
    function automatic query_t make_item(input int sx, input int sy, input int ex,
                                         input int ey, input int cx, input int cy,
                                         input int w, input int h);
        query_t q;
        q.start_x      = sx * Q;
        q.start_y      = sy * Q;
        q.end_x        = ex * Q;
        q.end_y        = ey * Q;
        q.box_center_x = cx * Q;
        q.box_center_y = cy * Q;
        q.box_width    = 31'(w * Q);
        q.box_height   = 31'(h * Q);
        return q;
    endfunction

    // Random item: mostly segments near a moderate box, some pure noise, some degenerate.
    function automatic query_t random_item();
        query_t q;
        int     roll;
        int     span;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        roll = $urandom_range(0, 99);
        q.start_x      = $urandom;
        q.start_y      = $urandom;
        q.end_x        = $urandom;
        q.end_y        = $urandom;
        q.box_center_x = $urandom;
        q.box_center_y = $urandom;
        q.box_width    = 31'($urandom);
        q.box_height   = 31'($urandom);
        if (roll < 15)
        begin
            return q;
        end
        span = 1 << $urandom_range(4, 26);
        cx = $signed($urandom_range(0, 32'h3fff_ffff)) - 32'sh2000_0000;
        cy = $signed($urandom_range(0, 32'h3fff_ffff)) - 32'sh2000_0000;
        q.box_center_x = cx;
        q.box_center_y = cy;
        q.box_width    = 31'($urandom_range(0, span));
        q.box_height   = 31'($urandom_range(0, span));
        q.start_x = cx + $signed($urandom_range(0, 2 * span)) - span;
        q.start_y = cy + $signed($urandom_range(0, 2 * span)) - span;
        q.end_x   = cx + $signed($urandom_range(0, 2 * span)) - span;
        q.end_y   = cy + $signed($urandom_range(0, 2 * span)) - span;
        if (roll >= 85)
        begin
            // Degenerate shapes: vertical, horizontal, a single point, or ends on edges.
            case ($urandom_range(0, 3))
                0: q.end_x = q.start_x;
                1: q.end_y = q.start_y;
                2: begin q.end_x = q.start_x; q.end_y = q.start_y; end
                default:
                begin
                    q.start_x = cx - $signed({1'b0, q.box_width >> 1});
                    q.end_y   = cy + $signed({1'b0, q.box_height >> 1});
                end
            endcase
        end
        return q;
    endfunction

    // Directed items first, then the random stream, then drain and give the verdict.
    initial
    begin
        query_t q;
        rst_n = 1'b0;
        start = 1'b0;
        query = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // One crossing on each edge of a box of half size two.
        send_item(make_item(1, -5, 1, 0, 0, 0, 4, 4), pick_gap());
        send_item(make_item(-5, 0, 0, 1, 0, 0, 4, 4), pick_gap());
        send_item(make_item(5, 0, 0, 1, 0, 0, 4, 4), pick_gap());
        send_item(make_item(-1, 4, 3, -4, 0, 0, 4, 4), pick_gap());
        // Rejection beyond each edge, and a crossing exactly through a corner.
        send_item(make_item(-9, -9, -2, 9, 0, 0, 4, 4), pick_gap());
        send_item(make_item(2, -9, 9, 9, 0, 0, 4, 4), pick_gap());
        send_item(make_item(-9, 2, 9, 9, 0, 0, 4, 4), pick_gap());
        send_item(make_item(-9, -2, 9, -9, 0, 0, 4, 4), pick_gap());
        send_item(make_item(-4, -4, 4, 4, 0, 0, 4, 4), pick_gap());
        // Vertical, horizontal and single-point segments inside the box.
        send_item(make_item(1, -1, 1, 1, 0, 0, 4, 4), pick_gap());
        send_item(make_item(-1, 1, 1, 1, 0, 0, 4, 4), pick_gap());
        send_item(make_item(0, 0, 0, 0, 0, 0, 4, 4), pick_gap());
        // Empty box.
        send_item(make_item(-3, -1, 3, 1, 0, 0, 0, 0), pick_gap());

        // Field extremes: full-size box at the range ends, so edges lie beyond the coordinate range.
        q.start_x = 32'sh8000_0000; q.start_y = 32'sh7fff_ffff;
        q.end_x   = 32'sh7fff_ffff; q.end_y   = 32'sh8000_0000;
        q.box_center_x = 32'sh7fff_ffff; q.box_center_y = 32'sh8000_0000;
        q.box_width = 31'h7fff_ffff; q.box_height = 31'h7fff_ffff;
        send_item(q, pick_gap());
        q.box_center_x = 32'sh8000_0000; q.box_center_y = 32'sh7fff_ffff;
        send_item(q, pick_gap());
        q.box_center_x = '0; q.box_center_y = '0;
        send_item(q, pick_gap());
        q.start_x = 32'sh8000_0000; q.start_y = 32'sh8000_0001;
        q.end_x   = 32'sh7fff_ffff; q.end_y   = 32'sh8000_0000;
        send_item(q, pick_gap());
        q = '0;
        send_item(q, pick_gap());
        q = '1;
        send_item(q, 0);
        send_item(q, 0);

        repeat (RandomItems)
        begin
            send_item(random_item(), pick_gap());
        end
        start <= 1'b0;

        // Wait for every expected result, then a little longer for strays.
        @(posedge clk);
        while (pending_count != 0)
        begin
            @(posedge clk);
        end
        repeat (DrainCycles) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Safety limit on the whole run.
    initial
    begin
        #1000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
